// ===== design/mrw_pkg.sv =====
// ----------------------------------------------------------------------------
// mrw_pkg
// Shared types and constants of the Morton rectangle walker.
// ----------------------------------------------------------------------------
`default_nettype none

package mrw_pkg;

   localparam int DATA_W = 32;
   localparam int ADDR_W = 4;

   // register indexes, byte address = 4 * index
   localparam logic [1:0] REG_MIN_X = 2'd0;
   localparam logic [1:0] REG_MIN_Z = 2'd1;
   localparam logic [1:0] REG_MAX_X = 2'd2;
   localparam logic [1:0] REG_MAX_Z = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_SEARCH,
      ST_BUILD,
      ST_FINISH
   } state_type;

   // where the emitted code comes from in the build pass
   typedef enum logic [1:0] {
      SRC_ZERO,
      SRC_CAND,
      SRC_SEARCH
   } src_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_DONE  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic [DATA_W-1:0] min_x;
      logic [DATA_W-1:0] min_z;
      logic [DATA_W-1:0] max_x;
      logic [DATA_W-1:0] max_z;
   } bounds_type;

   // sequencer to datapath
   typedef struct packed {
      logic    scan_init;
      logic    scan;
      logic    search_init;
      logic    search;
      logic    build_init;
      logic    build;
      src_type src;
   } step_type;

   // datapath to sequencer
   typedef struct packed {
      logic empty;
      logic ge;
      logic fits;
      logic stop;
      logic last;
   } flags_type;

endpackage

`default_nettype wire

// ===== design/morton_rectangle_walker_top.sv =====
// ----------------------------------------------------------------------------
// morton_rectangle_walker_top
// Walks an inclusive rectangle in Morton (Z) order, one position per request.
// ----------------------------------------------------------------------------
//  channel   dir   ports                                        meaning
//  req       in    req_valid/req_ready, req_restart             restart or next
//  rsp       out   rsp_valid/rsp_ready, rsp_pos_x/z, last, stat position/status
//  csr       in    psel/penable/pwrite/paddr/pwdata/prdata/pready  bounds regs
//
//  N = COORD_BITS. A transaction runs only the scan pass when it ends in a status
//  other than ok, scan and build passes for a restart or an adjacent next code,
//  and scan, BIGMIN search and build passes otherwise: each pass handles one of the 2N code bits per cycle.
//  Reset is synchronous and needs no clearing pass.
//  The result sits in an output register; a new transaction is taken while it
//  waits, and the next result holds in the finish state until the slot frees.
// ----------------------------------------------------------------------------
`default_nettype none

module morton_rectangle_walker_top #(
   parameter int COORD_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [mrw_pkg::ADDR_W-1:0]   paddr,
   input  logic [mrw_pkg::DATA_W-1:0]   pwdata,
   output logic [mrw_pkg::DATA_W-1:0]   prdata,
   output logic                         pready,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_restart,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [31:0]           rsp_pos_x,
   output logic signed [31:0]           rsp_pos_z,
   output logic                         rsp_last,
   output logic [1:0]                   rsp_status
);
   import mrw_pkg::*;

   localparam int KW = $clog2(2 * COORD_BITS);

   bounds_type                    bounds;
   step_type                      step;
   flags_type                     flags;
   logic [KW-1:0]                 bit_idx;
   logic                          load;
   logic                          rsp_free;
   status_type                    status;
   logic signed [COORD_BITS-1:0]  pos_x, pos_z;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_x_ff, rsp_x_in;
   logic signed [31:0] rsp_z_ff, rsp_z_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;

   mrw_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .bounds  (bounds)
   );

   mrw_datapath #(.COORD_BITS(COORD_BITS)) u_datapath (
      .clock   (clock),
      .reset   (reset),
      .bounds  (bounds),
      .step    (step),
      .bit_idx (bit_idx),
      .flags   (flags),
      .pos_x   (pos_x),
      .pos_z   (pos_z)
   );

   mrw_ctrl #(.COORD_BITS(COORD_BITS)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_restart (req_restart),
      .req_ready   (req_ready),
      .rsp_free    (rsp_free),
      .flags       (flags),
      .step        (step),
      .bit_idx     (bit_idx),
      .load        (load),
      .status      (status)
   );

   assign rsp_free = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_z_in      = rsp_z_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      if (load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status;
         if (status == STATUS_OK) begin
            rsp_x_in    = 32'(pos_x);
            rsp_z_in    = 32'(pos_z);
            rsp_last_in = flags.last;
         end else begin
            rsp_x_in    = '0;
            rsp_z_in    = '0;
            rsp_last_in = 1'b0;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_x_ff      <= rsp_x_in;
      rsp_z_ff      <= rsp_z_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign pready     = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_pos_x  = rsp_x_ff;
   assign rsp_pos_z  = rsp_z_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_status = rsp_status_ff;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK
         |-> rsp_pos_x == '0 && rsp_pos_z == '0 && !rsp_last)
      else $error("non-ok result carries a position");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transaction taken while one is in flight");

endmodule

`default_nettype wire

// ===== design/mrw_csr.sv =====
// ----------------------------------------------------------------------------
// mrw_csr
// APB register file holding the rectangle bounds.
// ----------------------------------------------------------------------------
`default_nettype none

module mrw_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [mrw_pkg::ADDR_W-1:0]   paddr,
   input  logic [mrw_pkg::DATA_W-1:0]   pwdata,
   output logic [mrw_pkg::DATA_W-1:0]   prdata,
   output mrw_pkg::bounds_type          bounds
);
   import mrw_pkg::*;

   bounds_type bounds_ff, bounds_in;
   logic       wr_en;
   logic [1:0] reg_sel;

   always_comb begin
      reg_sel   = paddr[ADDR_W-1:2];
      wr_en     = psel & penable & pwrite;
      bounds_in = bounds_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_MIN_X: bounds_in.min_x = pwdata;
            REG_MIN_Z: bounds_in.min_z = pwdata;
            REG_MAX_X: bounds_in.max_x = pwdata;
            REG_MAX_Z: bounds_in.max_z = pwdata;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_MIN_X: prdata = bounds_ff.min_x;
         REG_MIN_Z: prdata = bounds_ff.min_z;
         REG_MAX_X: prdata = bounds_ff.max_x;
         REG_MAX_Z: prdata = bounds_ff.max_z;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bounds_ff <= '0;
      end else begin
         bounds_ff <= bounds_in;
      end
   end

   assign bounds = bounds_ff;

endmodule

`default_nettype wire

// ===== design/mrw_datapath.sv =====
// ----------------------------------------------------------------------------
// mrw_datapath
// Bit-serial datapath: one code bit per cycle in each of three passes.
// ----------------------------------------------------------------------------
`default_nettype none

module mrw_datapath #(
   parameter int COORD_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mrw_pkg::bounds_type                  bounds,
   input  mrw_pkg::step_type                    step,
   input  logic [$clog2(2*COORD_BITS)-1:0]      bit_idx,
   output mrw_pkg::flags_type                   flags,
   output logic signed [COORD_BITS-1:0]         pos_x,
   output logic signed [COORD_BITS-1:0]         pos_z
);
   import mrw_pkg::*;

   localparam int CW = 2 * COORD_BITS;
   localparam int KW = $clog2(CW);
   localparam int JW = KW - 1;
   localparam logic [JW-1:0] J_MSB = JW'(COORD_BITS - 1);

   // current_code lives here; cand and max code are filled by the scan pass
   logic [CW-1:0]          code_ff, code_in;
   logic [CW-1:0]          cand_ff, cand_in;
   logic [CW-1:0]          mx_ff, mx_in;
   logic [COORD_BITS-1:0]  posx_ff, posx_in;
   logic [COORD_BITS-1:0]  posz_ff, posz_in;

   logic br_x_ff, br_x_in, br_z_ff, br_z_in;
   logic cy_ff, cy_in;
   logic le_x_ff, le_x_in, le_z_ff, le_z_in;
   logic ge_ff, ge_in;
   logic empty_x_ff, empty_x_in, empty_z_ff, empty_z_in;
   logic [1:0]    hio_ff, hio_in;
   logic          found_ff, found_in;
   logic [KW-1:0] bpos_ff, bpos_in;
   logic cx_ff, cx_in, cz_ff, cz_in;
   logic eq_ff, eq_in;

   logic [COORD_BITS-1:0] min_x_c, min_z_c, max_x_c, max_z_c;
   logic          dim;
   logic [JW-1:0] j;
   logic min_b, max_b, br, diff_b, br_out, br_flip;
   logic cur_b, cand_b, le, le_next, ge_next;
   logic s_c, s_h, stop;
   logic code_b, carry, sum_b, carry_out;

   always_comb begin
      min_x_c = bounds.min_x[COORD_BITS-1:0];
      min_z_c = bounds.min_z[COORD_BITS-1:0];
      max_x_c = bounds.max_x[COORD_BITS-1:0];
      max_z_c = bounds.max_z[COORD_BITS-1:0];
      dim     = bit_idx[0];
      j       = bit_idx[KW-1:1];
      min_b   = dim ? min_z_c[j] : min_x_c[j];
      max_b   = dim ? max_z_c[j] : max_x_c[j];

      // serial subtract max - min gives the offset extent (max code bit)
      br      = dim ? br_z_ff : br_x_ff;
      diff_b  = max_b ^ min_b ^ br;
      br_out  = (~max_b & min_b) | (~(max_b ^ min_b) & br);
      // same borrow with sign bits flipped: signed min > max
      br_flip = (max_b & ~min_b) | (~(max_b ^ min_b) & br);

      // cand = current + 1, compared per axis against the extent
      cur_b   = code_ff[bit_idx];
      cand_b  = cur_b ^ cy_ff;
      le      = dim ? le_z_ff : le_x_ff;
      le_next = (cand_b == diff_b) ? le : (diff_b & ~cand_b);
      ge_next = (cur_b == diff_b) ? ge_ff : (cur_b & ~diff_b);

      // BIGMIN step, MSB first; hi of an axis turns all ones once cut
      s_c  = cand_ff[bit_idx];
      s_h  = hio_ff[dim] | mx_ff[bit_idx];
      stop = s_c & ~s_h;

      unique case (step.src)
         SRC_ZERO:   code_b = 1'b0;
         SRC_CAND:   code_b = cand_ff[bit_idx];
         SRC_SEARCH: begin
            if (!found_ff) begin
               code_b = mx_ff[bit_idx];
            end else if (bit_idx > bpos_ff) begin
               code_b = cand_ff[bit_idx];
            end else begin
               code_b = (bit_idx == bpos_ff);
            end
         end
         default:    code_b = 1'b0;
      endcase
      carry     = dim ? cz_ff : cx_ff;
      sum_b     = min_b ^ code_b ^ carry;
      carry_out = (min_b & code_b) | (min_b & carry) | (code_b & carry);
   end

   always_comb begin
      code_in    = code_ff;
      cand_in    = cand_ff;
      mx_in      = mx_ff;
      posx_in    = posx_ff;
      posz_in    = posz_ff;
      br_x_in    = br_x_ff;
      br_z_in    = br_z_ff;
      cy_in      = cy_ff;
      le_x_in    = le_x_ff;
      le_z_in    = le_z_ff;
      ge_in      = ge_ff;
      empty_x_in = empty_x_ff;
      empty_z_in = empty_z_ff;
      hio_in     = hio_ff;
      found_in   = found_ff;
      bpos_in    = bpos_ff;
      cx_in      = cx_ff;
      cz_in      = cz_ff;
      eq_in      = eq_ff;

      if (step.scan_init) begin
         br_x_in    = 1'b0;
         br_z_in    = 1'b0;
         cy_in      = 1'b1;
         le_x_in    = 1'b1;
         le_z_in    = 1'b1;
         ge_in      = 1'b1;
         empty_x_in = 1'b0;
         empty_z_in = 1'b0;
      end
      if (step.scan) begin
         cand_in = {cand_b, cand_ff[CW-1:1]};
         mx_in   = {diff_b, mx_ff[CW-1:1]};
         cy_in   = cur_b & cy_ff;
         ge_in   = ge_next;
         if (dim) begin
            br_z_in = br_out;
            le_z_in = le_next;
            if (j == J_MSB) begin
               empty_z_in = br_flip;
            end
         end else begin
            br_x_in = br_out;
            le_x_in = le_next;
            if (j == J_MSB) begin
               empty_x_in = br_flip;
            end
         end
      end

      if (step.search_init) begin
         hio_in   = 2'b00;
         found_in = 1'b0;
      end
      if (step.search && !s_c && s_h) begin
         found_in     = 1'b1;
         bpos_in      = bit_idx;
         hio_in[dim]  = 1'b1;
      end

      if (step.build_init) begin
         cx_in = 1'b0;
         cz_in = 1'b0;
         eq_in = 1'b1;
      end
      if (step.build) begin
         code_in = {code_b, code_ff[CW-1:1]};
         eq_in   = eq_ff & (code_b == mx_ff[bit_idx]);
         if (dim) begin
            posz_in = {sum_b, posz_ff[COORD_BITS-1:1]};
            cz_in   = carry_out;
         end else begin
            posx_in = {sum_b, posx_ff[COORD_BITS-1:1]};
            cx_in   = carry_out;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff <= '0;
      end else begin
         code_ff <= code_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff    <= cand_in;
      mx_ff      <= mx_in;
      posx_ff    <= posx_in;
      posz_ff    <= posz_in;
      br_x_ff    <= br_x_in;
      br_z_ff    <= br_z_in;
      cy_ff      <= cy_in;
      le_x_ff    <= le_x_in;
      le_z_ff    <= le_z_in;
      ge_ff      <= ge_in;
      empty_x_ff <= empty_x_in;
      empty_z_ff <= empty_z_in;
      hio_ff     <= hio_in;
      found_ff   <= found_in;
      bpos_ff    <= bpos_in;
      cx_ff      <= cx_in;
      cz_ff      <= cz_in;
      eq_ff      <= eq_in;
   end

   always_comb begin
      flags.empty = empty_x_ff | empty_z_ff;
      flags.ge    = ge_ff;
      flags.fits  = le_x_ff & le_z_ff;
      flags.stop  = stop;
      flags.last  = eq_ff;
   end

   assign pos_x = posx_ff;
   assign pos_z = posz_ff;

endmodule

`default_nettype wire

// ===== design/mrw_ctrl.sv =====
// ----------------------------------------------------------------------------
// mrw_ctrl
// Sequencer: scan, decide, BIGMIN search and build passes, walk state.
// ----------------------------------------------------------------------------
`default_nettype none

module mrw_ctrl #(
   parameter int COORD_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_restart,
   output logic                              req_ready,
   input  logic                              rsp_free,
   input  mrw_pkg::flags_type                flags,
   output mrw_pkg::step_type                 step,
   output logic [$clog2(2*COORD_BITS)-1:0]   bit_idx,
   output logic                              load,
   output mrw_pkg::status_type               status
);
   import mrw_pkg::*;

   localparam int KW = $clog2(2 * COORD_BITS);
   localparam logic [KW-1:0] K_LAST = KW'(2 * COORD_BITS - 1);

   state_type     state_ff, state_in;
   logic [KW-1:0] k_ff, k_in;
   logic          restart_ff, restart_in;
   logic          active_ff, active_in;
   status_type    status_ff, status_in;
   src_type       src_ff, src_in;

   always_comb begin
      state_in   = state_ff;
      k_in       = k_ff;
      restart_in = restart_ff;
      active_in  = active_ff;
      status_in  = status_ff;
      src_in     = src_ff;
      step       = '0;
      step.src   = src_ff;
      req_ready  = 1'b0;
      load       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               restart_in     = req_restart;
               k_in           = '0;
               step.scan_init = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            step.scan = 1'b1;
            k_in      = k_ff + 1'b1;
            if (k_ff == K_LAST) begin
               k_in     = '0;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            status_in = STATUS_OK;
            priority if (restart_ff && flags.empty) begin
               status_in = STATUS_EMPTY;
               active_in = 1'b0;
               state_in  = ST_FINISH;
            end else if (restart_ff) begin
               src_in          = SRC_ZERO;
               step.build_init = 1'b1;
               state_in        = ST_BUILD;
            end else if (!active_ff) begin
               status_in = STATUS_DONE;
               state_in  = ST_FINISH;
            end else if (flags.empty) begin
               status_in = STATUS_EMPTY;
               active_in = 1'b0;
               state_in  = ST_FINISH;
            end else if (flags.ge) begin
               status_in = STATUS_DONE;
               active_in = 1'b0;
               state_in  = ST_FINISH;
            end else if (flags.fits) begin
               src_in          = SRC_CAND;
               step.build_init = 1'b1;
               state_in        = ST_BUILD;
            end else begin
               step.search_init = 1'b1;
               k_in             = K_LAST;
               state_in         = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            step.search = 1'b1;
            k_in        = k_ff - 1'b1;
            if (flags.stop || k_ff == '0) begin
               k_in            = '0;
               src_in          = SRC_SEARCH;
               step.build_init = 1'b1;
               state_in        = ST_BUILD;
            end
         end
         ST_BUILD: begin
            step.build = 1'b1;
            k_in       = k_ff + 1'b1;
            if (k_ff == K_LAST) begin
               k_in     = '0;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status_ff == STATUS_OK) begin
               active_in = ~flags.last;
            end
            if (rsp_free) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         k_ff      <= '0;
         active_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         k_ff      <= k_in;
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      restart_ff <= restart_in;
      status_ff  <= status_in;
      src_ff     <= src_in;
   end

   assign bit_idx = k_ff;
   assign status  = status_ff;

   // the search only runs for a next request inside a live walk
   a_search_in_walk: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEARCH |-> !restart_ff && active_ff)
      else $error("search pass outside an active walk");

   a_zero_on_restart: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_BUILD && src_ff == SRC_ZERO |-> restart_ff)
      else $error("minimum corner built without restart");

endmodule

`default_nettype wire
